// File: rtl/led_matrix_row_scan_serializer_defines.svh
// ----------------------------------------------------------------------------
// LED matrix row scan serializer: assertion macros
// Shared check macros, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LED_MATRIX_ROW_SCAN_SERIALIZER_DEFINES_SVH
`define LED_MATRIX_ROW_SCAN_SERIALIZER_DEFINES_SVH

// same-cycle implication
`define LMRS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lmrs same-cycle check failed");

// next-cycle implication
`define LMRS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lmrs next-cycle check failed");

`endif

// File: rtl/lmrs_pkg.sv
// ----------------------------------------------------------------------------
// LED matrix row scan serializer: package
// Default geometry, field widths, command codes and control structs.
// ----------------------------------------------------------------------------
package lmrs_pkg;

    localparam int COLUMNS_DEF = 16;
    localparam int ROWS_DEF    = 8;
    localparam int BYTE_BITS   = 8;
    localparam int MAX_RUN     = 64;
    localparam int CMD_W       = 2;
    localparam int PIX_IDX_W   = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_SCAN    = 2'd0,
        CMD_WRITE   = 2'd1,
        CMD_TAKE    = 2'd2,
        CMD_RELEASE = 2'd3
    } cmd_t;

    typedef struct packed {
        logic clear;
        logic pix_wr;
        logic scan_start;
        logic emit;
        logic advance;
        logic copy;
    } ctl_cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic out_free;
        logic run_last;
        logic row_wrap;
    } ctl_status_t;

endpackage

// File: rtl/lmrs_if.sv
// ----------------------------------------------------------------------------
// LED matrix row scan serializer: channel interfaces
// Command channel in, serial bit channel out, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lmrs_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [lmrs_pkg::CMD_W-1:0]     cmd;
    logic [lmrs_pkg::PIX_IDX_W-1:0] pixel_index;
    logic                           pixel_value;

    modport source (output valid, cmd, pixel_index, pixel_value, input ready);
    modport sink   (input valid, cmd, pixel_index, pixel_value, output ready);
endinterface

interface lmrs_bit_if;
    logic valid;
    logic ready;
    logic serial_data;
    logic latch_pulse;
    logic last;

    modport source (output valid, serial_data, latch_pulse, last, input ready);
    modport sink   (input valid, serial_data, latch_pulse, last, output ready);
endinterface

// File: rtl/lmrs_ram.sv
// ----------------------------------------------------------------------------
// LED matrix row scan serializer: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lmrs_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/lmrs_ctrl.sv
// ----------------------------------------------------------------------------
// LED matrix row scan serializer: controller
// Clear pass, command decode, bit emission and frame copy sequencing.
// ----------------------------------------------------------------------------
`include "led_matrix_row_scan_serializer_defines.svh"

module lmrs_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [lmrs_pkg::CMD_W-1:0] in_cmd,
    output logic                       in_ready,
    output lmrs_pkg::ctl_cmd_t         ctl,
    input  lmrs_pkg::ctl_status_t      sts
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EMIT,
        ST_COPY
    } state_t;

    state_t state_reg;
    logic   busy_reg;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_ready && in_valid;

    always_comb
    begin
        ctl            = '0;
        ctl.clear      = (state_reg == ST_CLEAR);
        ctl.pix_wr     = accept && (in_cmd == lmrs_pkg::CMD_WRITE);
        ctl.scan_start = accept && (in_cmd == lmrs_pkg::CMD_SCAN);
        ctl.emit       = (state_reg == ST_EMIT) && sts.out_free;
        ctl.advance    = ctl.emit && sts.run_last;
        ctl.copy       = (state_reg == ST_COPY);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            busy_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_CLEAR:
                begin
                    if (sts.sweep_last)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (in_cmd)
                            lmrs_pkg::CMD_SCAN:    state_reg <= ST_EMIT;
                            lmrs_pkg::CMD_TAKE:    busy_reg  <= 1'b1;
                            lmrs_pkg::CMD_RELEASE: busy_reg  <= 1'b0;
                            default:               state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_EMIT:
                begin
                    if (ctl.advance)
                    begin
                        state_reg <= (sts.row_wrap && !busy_reg) ? ST_COPY : ST_IDLE;
                    end
                end
                ST_COPY:
                begin
                    if (sts.sweep_last)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `LMRS_ASSERT_NXT(a_copy_on_wrap, ctl.advance && sts.row_wrap && !busy_reg, state_reg == ST_COPY)
    `LMRS_ASSERT_IMP(a_busy_from_cmd, $rose(busy_reg), $past(accept))

endmodule

// File: rtl/lmrs_datapath.sv
// ----------------------------------------------------------------------------
// LED matrix row scan serializer: datapath
// Frame memories, row fetch buffer, bit counters and output register.
// ----------------------------------------------------------------------------
`include "led_matrix_row_scan_serializer_defines.svh"

module lmrs_datapath #(
    parameter int COLUMNS = lmrs_pkg::COLUMNS_DEF,
    parameter int ROWS    = lmrs_pkg::ROWS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lmrs_pkg::ctl_cmd_t             ctl,
    output lmrs_pkg::ctl_status_t          sts,
    input  logic [lmrs_pkg::PIX_IDX_W-1:0] pixel_index,
    input  logic                           pixel_value,
    lmrs_bit_if.source                     bit_ch
);

    localparam int PIXELS     = COLUMNS * ROWS;
    localparam int AW         = $clog2(PIXELS);
    localparam int RW         = $clog2(ROWS);
    localparam int CNW        = $clog2(COLUMNS + 1);
    localparam int FRAME_BITS = ((COLUMNS + ROWS + lmrs_pkg::BYTE_BITS - 1)
                                 / lmrs_pkg::BYTE_BITS) * lmrs_pkg::BYTE_BITS;
    localparam int PW         = $clog2(FRAME_BITS + 1);
    localparam int RUN_BITS   = (2 * FRAME_BITS < lmrs_pkg::MAX_RUN) ?
                                (2 * FRAME_BITS) : lmrs_pkg::MAX_RUN;
    localparam int TW         = $clog2(RUN_BITS + 1);
    localparam int XW         = ((AW > lmrs_pkg::PIX_IDX_W) ? AW : lmrs_pkg::PIX_IDX_W) + 1;

    logic [AW-1:0]      sweep_reg;
    logic               copy_wr_reg;
    logic [AW-1:0]      copy_addr_reg;
    logic [RW-1:0]      row_reg;
    logic [AW-1:0]      row_base_reg;
    logic               fetch_active_reg;
    logic               fetch_rd_reg;
    logic [CNW-1:0]     fetch_cnt_reg;
    logic               frame_reg;
    logic [PW-1:0]      pos_reg;
    logic [TW-1:0]      total_reg;
    logic               out_valid_reg;
    logic               out_data_reg;
    logic               out_latch_reg;
    logic               out_last_reg;
    logic [COLUMNS-1:0] buf_reg;
    logic [COLUMNS-1:0] buf_next;

    logic [XW-1:0]      idx_x;
    logic               idx_ok;
    logic               stg_we;
    logic [AW-1:0]      stg_wa;
    logic [0:0]         stg_wd;
    logic [0:0]         stg_rdata;
    logic               dsp_we;
    logic [AW-1:0]      dsp_wa;
    logic [0:0]         dsp_wd;
    logic [AW-1:0]      fetch_addr;
    logic [0:0]         dsp_rdata;

    logic               fetch_last;
    logic               frame_end;
    logic               in_cols;
    logic               in_sel;
    logic [RW-1:0]      prev_row;
    logic [RW-1:0]      sel_row;
    logic [PW-1:0]      sel_pos;
    logic               bit_value;
    logic               latch_value;

    assign idx_x  = XW'(pixel_index);
    assign idx_ok = (idx_x < XW'(PIXELS));

    assign stg_we = ctl.clear || (ctl.pix_wr && idx_ok);
    assign stg_wa = ctl.clear ? sweep_reg : idx_x[AW-1:0];
    assign stg_wd = ctl.clear ? 1'b0 : pixel_value;

    assign dsp_we = ctl.clear || copy_wr_reg;
    assign dsp_wa = ctl.clear ? sweep_reg : copy_addr_reg;
    assign dsp_wd = ctl.clear ? 1'b0 : stg_rdata;

    assign fetch_addr = row_base_reg + AW'(fetch_cnt_reg);

    lmrs_ram #(
        .WIDTH (1),
        .DEPTH (PIXELS)
    ) u_staging (
        .clk     (clk),
        .wr_en   (stg_we),
        .wr_addr (stg_wa),
        .wr_data (stg_wd),
        .rd_addr (sweep_reg),
        .rd_data (stg_rdata)
    );

    lmrs_ram #(
        .WIDTH (1),
        .DEPTH (PIXELS)
    ) u_displayed (
        .clk     (clk),
        .wr_en   (dsp_we),
        .wr_addr (dsp_wa),
        .wr_data (dsp_wd),
        .rd_addr (fetch_addr),
        .rd_data (dsp_rdata)
    );

    assign fetch_last = (fetch_cnt_reg == CNW'(COLUMNS - 1));
    assign frame_end  = (pos_reg == PW'(FRAME_BITS - 1));
    assign in_cols    = (pos_reg < PW'(COLUMNS));
    assign in_sel     = (pos_reg < PW'(COLUMNS + ROWS));
    assign prev_row   = (row_reg == '0) ? RW'(ROWS - 1) : (row_reg - RW'(1));
    assign sel_row    = frame_reg ? row_reg : prev_row;
    assign sel_pos    = PW'(COLUMNS + ROWS - 1) - PW'(sel_row);

    always_comb
    begin
        if (in_cols)
        begin
            bit_value = frame_reg ? ~buf_reg[0] : 1'b1;
        end
        else if (in_sel)
        begin
            bit_value = (pos_reg == sel_pos);
        end
        else
        begin
            bit_value = frame_reg && (row_reg == '0);
        end
    end

    assign sts.run_last   = (total_reg == TW'(RUN_BITS - 1));
    assign sts.sweep_last = (sweep_reg == AW'(PIXELS - 1));
    assign sts.row_wrap   = (row_reg == RW'(ROWS - 1));
    assign sts.out_free   = !out_valid_reg || bit_ch.ready;

    assign latch_value = sts.run_last || (!frame_reg && frame_end);

    always_comb
    begin
        buf_next = buf_reg;
        if (fetch_rd_reg)
        begin
            buf_next = buf_reg >> 1;
            buf_next[COLUMNS-1] = dsp_rdata[0];
        end
        else if (ctl.emit && frame_reg && in_cols)
        begin
            buf_next = buf_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg        <= '0;
            copy_wr_reg      <= 1'b0;
            row_reg          <= '0;
            row_base_reg     <= '0;
            fetch_active_reg <= 1'b0;
            fetch_rd_reg     <= 1'b0;
            fetch_cnt_reg    <= '0;
            frame_reg        <= 1'b0;
            pos_reg          <= '0;
            total_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (ctl.clear || ctl.copy)
            begin
                sweep_reg <= sts.sweep_last ? '0 : (sweep_reg + AW'(1));
            end
            copy_wr_reg <= ctl.copy;

            if (ctl.advance)
            begin
                row_reg      <= sts.row_wrap ? '0 : (row_reg + RW'(1));
                row_base_reg <= sts.row_wrap ? '0 : (row_base_reg + AW'(COLUMNS));
            end

            fetch_rd_reg <= fetch_active_reg;
            if (ctl.scan_start)
            begin
                fetch_active_reg <= 1'b1;
                fetch_cnt_reg    <= '0;
            end
            else if (fetch_active_reg)
            begin
                fetch_cnt_reg <= fetch_cnt_reg + CNW'(1);
                if (fetch_last)
                begin
                    fetch_active_reg <= 1'b0;
                end
            end

            if (ctl.scan_start)
            begin
                frame_reg <= 1'b0;
                pos_reg   <= '0;
                total_reg <= '0;
            end
            else if (ctl.emit)
            begin
                total_reg <= total_reg + TW'(1);
                if (frame_end)
                begin
                    pos_reg   <= '0;
                    frame_reg <= 1'b1;
                end
                else
                begin
                    pos_reg <= pos_reg + PW'(1);
                end
            end

            if (ctl.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (bit_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg       <= buf_next;
        copy_addr_reg <= sweep_reg;
        if (ctl.emit)
        begin
            out_data_reg  <= bit_value;
            out_latch_reg <= latch_value;
            out_last_reg  <= sts.run_last;
        end
    end

    assign bit_ch.valid       = out_valid_reg;
    assign bit_ch.serial_data = out_data_reg;
    assign bit_ch.latch_pulse = out_latch_reg;
    assign bit_ch.last        = out_last_reg;

    `LMRS_ASSERT_IMP(a_row_buf_ready, ctl.emit && frame_reg && in_cols, !fetch_active_reg && !fetch_rd_reg)
    `LMRS_ASSERT_IMP(a_row_base_zero, row_reg == '0, row_base_reg == '0)
    `LMRS_ASSERT_IMP(a_last_latches, out_valid_reg && out_last_reg, out_latch_reg)

endmodule

// File: rtl/led_matrix_row_scan_serializer.sv
// ----------------------------------------------------------------------------
// LED matrix row scan serializer: top level
// Takes matrix commands and shifts row scan frames out one bit per item.
// ----------------------------------------------------------------------------
// cmd_ch carries commands: scan one row, write a staging pixel, take or
// release the buffer. bit_ch carries one item per shift clock pulse: the
// data level, a latch flag on the final bit of the first frame and of the
// scan, and last on the final bit of a scan.
// Write, take and release give no bit items.
// A scan gives two frames of COLUMNS+ROWS bits rounded up to whole bytes
// (48 bits at 16x8), capped at 64; the first bit leaves after the
// controller enters its emit state and the output register loads, then
// one bit per cycle while bit_ch is ready. The row buffer fetch from the
// displayed memory runs during the blanking frame.
// When the row wraps and the buffer is not taken, the staging memory is
// copied into the displayed memory, one pixel per cycle, before the next
// command is taken.
// After reset both memories are cleared, one pixel per cycle, before
// cmd_ch.ready rises.
// A stall on bit_ch holds the output register and the scan simply waits.
// ----------------------------------------------------------------------------
module led_matrix_row_scan_serializer #(
    parameter int COLUMNS = lmrs_pkg::COLUMNS_DEF,
    parameter int ROWS    = lmrs_pkg::ROWS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    lmrs_cmd_if.sink   cmd_ch,
    lmrs_bit_if.source bit_ch
);

    lmrs_pkg::ctl_cmd_t    ctl;
    lmrs_pkg::ctl_status_t sts;
    logic                  in_ready;

    assign cmd_ch.ready = in_ready;

    lmrs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd_ch.valid),
        .in_cmd   (cmd_ch.cmd),
        .in_ready (in_ready),
        .ctl      (ctl),
        .sts      (sts)
    );

    lmrs_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .sts         (sts),
        .pixel_index (cmd_ch.pixel_index),
        .pixel_value (cmd_ch.pixel_value),
        .bit_ch      (bit_ch)
    );

endmodule
